// File: rtl/bate_pkg.sv
// Shared constants, codes and controller/datapath link types for the table engine.
`default_nettype none

package bate_pkg;

	localparam int DEPTH   = 256;
	localparam int VW      = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CAP_W   = 9;
	localparam int IDX_W   = 9;
	localparam int IN_W    = 32;
	localparam int RES_W   = 40;
	localparam int RI_W    = 8;
	localparam int DCNT_W  = $clog2(RES_W);

	localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

	typedef enum logic [3:0] {
		CMD_APPEND = 4'd0,
		CMD_INSERT = 4'd1,
		CMD_DELETE = 4'd2,
		CMD_SRCH   = 4'd3,
		CMD_SRCH_T = 4'd4,
		CMD_SRCH_H = 4'd5,
		CMD_BINARY = 4'd6,
		CMD_GET    = 4'd7,
		CMD_SET    = 4'd8,
		CMD_MAX    = 4'd9,
		CMD_MIN    = 4'd10,
		CMD_SUM    = 4'd11,
		CMD_AVG    = 4'd12
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_MISS  = 2'd2,
		ST_EMPTY = 2'd3
	} st_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_APPEND,
		OP_RD_PREV,
		OP_WR_DEC,
		OP_INS_END,
		OP_RD_PTR,
		OP_DEL_CAP,
		OP_RD_NEXT,
		OP_WR_INC,
		OP_DEL_END,
		OP_NEXT,
		OP_FOUND,
		OP_SWAP_RD,
		OP_SWAP_WR,
		OP_SWAP_KEY,
		OP_RD_MID,
		OP_BIN_HIT,
		OP_BIN_STEP,
		OP_GET,
		OP_SET,
		OP_ACC,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		st_t    status;
	} dp_ctrl_t;

	typedef struct packed {
		logic can_add;
		logic idx_le_fill;
		logic idx_lt_fill;
		logic fill_zero;
		logic ptr_gt_idx;
		logic ptr_lt_fill;
		logic ptr_next_lt_fill;
		logic ptr_zero;
		logic match;
		logic bin_open;
		logic div_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/bate_dp.sv
// Datapath of the table engine: entry memory, fill count, walk pointer, accumulators, divider.
`default_nettype none

module bate_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [3:0]                  command,
	input  wire logic [bate_pkg::IDX_W-1:0]  index,
	input  wire logic signed [bate_pkg::IN_W-1:0] value,
	input  wire logic                        cfg_we,
	input  wire logic [bate_pkg::CAP_W-1:0]  cfg_data,
	input  wire bate_pkg::dp_ctrl_t          ctrl,
	output bate_pkg::dp_stat_t               stat,
	output logic                             done,
	output logic [1:0]                       status,
	output logic signed [bate_pkg::RES_W-1:0] result_value,
	output logic [bate_pkg::RI_W-1:0]        result_index
);
	import bate_pkg::*;

	logic signed [VW-1:0]    mem [DEPTH];

	cmd_t                    cmd_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VW-1:0]    key_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        fill_q;
	logic [CAP_W-1:0]        cap_q;
	logic signed [VW-1:0]    rd_q;
	logic signed [RES_W-1:0] rv_q;
	logic signed [VW-1:0]    best_q;
	logic signed [RES_W-1:0] acc_q;
	logic [ADDR_W-1:0]       found_q;
	logic signed [CNT_W:0]   lo_q;
	logic signed [CNT_W:0]   hi_q;
	logic [ADDR_W-1:0]       mid_q;
	logic [CNT_W:0]          rem_q;
	logic [RES_W-1:0]        quo_q;
	logic                    neg_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic                    done_q;
	logic [1:0]              status_q;
	logic signed [RES_W-1:0] result_value_q;
	logic [RI_W-1:0]         result_index_q;

	logic                    rd_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic signed [VW-1:0]    wr_data;
	logic [ADDR_W-1:0]       swap_addr;
	logic signed [CNT_W:0]   bsum;
	logic [ADDR_W-1:0]       mid;
	logic [CNT_W:0]          rem_sh;
	logic                    better;
	cmd_t                    cmd_in;

	assign cmd_in    = cmd_t'(command);
	assign swap_addr = (cmd_q == CMD_SRCH_T) ? ADDR_W'(ptr_q - 1'b1) : '0;
	assign bsum      = lo_q + hi_q;
	assign mid       = ADDR_W'(bsum >>> 1);
	assign rem_sh    = {rem_q[CNT_W-1:0], quo_q[RES_W-1]};
	assign better    = (cmd_q == CMD_MAX) ? (rd_q > best_q) : (rd_q < best_q);

	always_comb begin
		stat.can_add          = (fill_q < cap_q) && (fill_q < DEPTH);
		stat.idx_le_fill      = idx_q <= fill_q;
		stat.idx_lt_fill      = idx_q < fill_q;
		stat.fill_zero        = fill_q == '0;
		stat.ptr_gt_idx       = ptr_q > idx_q;
		stat.ptr_lt_fill      = ptr_q < fill_q;
		stat.ptr_next_lt_fill = ((CNT_W+1)'(ptr_q) + 1'b1) < fill_q;
		stat.ptr_zero         = ptr_q == '0;
		stat.match            = rd_q == key_q;
		stat.bin_open         = lo_q <= hi_q;
		stat.div_last         = dcnt_q == DCNT_W'(RES_W - 1);
	end

	// memory port steering
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(ptr_q);
		wr_en   = 1'b0;
		wr_addr = ADDR_W'(ptr_q);
		wr_data = rd_q;
		case (ctrl.op)
			OP_RD_PREV: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(ptr_q - 1'b1);
			end
			OP_RD_PTR:  rd_en = 1'b1;
			OP_RD_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(ptr_q + 1'b1);
			end
			OP_RD_MID: begin
				rd_en   = 1'b1;
				rd_addr = mid;
			end
			OP_SWAP_RD: begin
				rd_en   = 1'b1;
				rd_addr = swap_addr;
			end
			OP_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(fill_q);
				wr_data = key_q;
			end
			OP_WR_DEC, OP_WR_INC, OP_SWAP_WR: wr_en = 1'b1;
			OP_INS_END, OP_SET: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(idx_q);
				wr_data = key_q;
			end
			OP_SWAP_KEY: begin
				wr_en   = 1'b1;
				wr_addr = found_q;
				wr_data = key_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// control state: fill count, capacity, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cap_q  <= CAP_W'(256);
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.op == OP_FINISH;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			case (ctrl.op)
				OP_APPEND, OP_INS_END: fill_q <= fill_q + 1'b1;
				OP_DEL_END:            fill_q <= fill_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LATCH: begin
				cmd_q   <= cmd_in;
				idx_q   <= index;
				key_q   <= value[VW-1:0];
				acc_q   <= '0;
				found_q <= '0;
				lo_q    <= '0;
				hi_q    <= $signed({1'b0, fill_q}) - 1'b1;
				best_q  <= (cmd_in == CMD_MAX) ? VAL_MIN : VAL_MAX;
				rv_q    <= (cmd_in == CMD_GET) ? '1 : '0;
				case (cmd_in)
					CMD_INSERT:                   ptr_q <= fill_q;
					CMD_DELETE, CMD_GET, CMD_SET: ptr_q <= CNT_W'(index);
					default:                      ptr_q <= '0;
				endcase
			end
			OP_APPEND:   found_q <= ADDR_W'(fill_q);
			OP_WR_DEC:   ptr_q   <= ptr_q - 1'b1;
			OP_INS_END, OP_DEL_END, OP_SET: found_q <= ADDR_W'(idx_q);
			OP_DEL_CAP:  rv_q    <= RES_W'(rd_q);
			OP_WR_INC, OP_NEXT: ptr_q <= ptr_q + 1'b1;
			OP_FOUND:    found_q <= ADDR_W'(ptr_q);
			OP_SWAP_RD:  found_q <= swap_addr;
			OP_RD_MID:   mid_q   <= mid;
			OP_BIN_HIT:  found_q <= mid_q;
			OP_BIN_STEP: begin
				if (key_q < rd_q) begin
					hi_q <= $signed((CNT_W+1)'(mid_q)) - 1'b1;
				end else begin
					lo_q <= $signed((CNT_W+1)'(mid_q)) + 1'b1;
				end
			end
			OP_GET: begin
				rv_q    <= RES_W'(rd_q);
				found_q <= ADDR_W'(idx_q);
			end
			OP_ACC: begin
				acc_q <= acc_q + RES_W'(rd_q);
				ptr_q <= ptr_q + 1'b1;
				if (better) begin
					best_q <= rd_q;
				end
			end
			OP_DIV_INIT: begin
				neg_q  <= acc_q[RES_W-1];
				quo_q  <= acc_q[RES_W-1] ? -acc_q : acc_q;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			OP_DIV_STEP: begin
				dcnt_q <= dcnt_q + 1'b1;
				if (rem_sh >= fill_q) begin
					rem_q <= rem_sh - fill_q;
					quo_q <= {quo_q[RES_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[RES_W-2:0], 1'b0};
				end
			end
			OP_FINISH: begin
				status_q       <= ctrl.status;
				result_index_q <= RI_W'(found_q);
				case (cmd_q)
					CMD_MAX, CMD_MIN: result_value_q <= RES_W'(best_q);
					CMD_SUM:          result_value_q <= acc_q;
					CMD_AVG: begin
						if (ctrl.status == ST_OK) begin
							result_value_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
						end else begin
							result_value_q <= '0;
						end
					end
					default:          result_value_q <= rv_q;
				endcase
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_value = result_value_q;
	assign result_index = result_index_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH)
		else $error("fill count beyond table depth");
	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_APPEND || ctrl.op == OP_INS_END) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("fill count did not grow by one");
	a_fill_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_DEL_END |=> fill_q == $past(fill_q) - 1'b1)
		else $error("fill count did not shrink by one");
`endif

endmodule

`default_nettype wire

// File: rtl/bate_ctrl.sv
// Controller state machine of the table engine: sequences one command over the datapath.
`default_nettype none

module bate_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [3:0]         command,
	input  wire bate_pkg::dp_stat_t stat,
	output bate_pkg::dp_ctrl_t      ctrl,
	output logic                    busy
);
	import bate_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_INS_RD, S_INS_WR, S_DEL_CAP, S_DEL_RD, S_DEL_WR,
		S_SRCH_RD, S_SRCH_CMP, S_SWAP_WR, S_SWAP_KEY, S_BIN_RD, S_BIN_CMP,
		S_GET_CAP, S_RED_RD, S_RED_ACC, S_DIV, S_FINISH
	} state_t;

	state_t state_q, state_n;
	cmd_t   cmd_q, cmd_n;
	st_t    st_q, st_n;
	dp_op_t op;

	always_comb begin
		state_n = state_q;
		cmd_n   = cmd_q;
		st_n    = st_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = OP_LATCH;
					cmd_n   = cmd_t'(command);
					st_n    = ST_OK;
					state_n = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (cmd_q) inside
					CMD_APPEND: begin
						state_n = S_FINISH;
						if (stat.can_add) begin
							op = OP_APPEND;
						end else begin
							st_n = ST_BAD;
						end
					end
					CMD_INSERT: begin
						if (stat.can_add && stat.idx_le_fill) begin
							state_n = S_INS_RD;
						end else begin
							st_n    = ST_BAD;
							state_n = S_FINISH;
						end
					end
					CMD_DELETE, CMD_GET: begin
						if (stat.idx_lt_fill) begin
							op      = OP_RD_PTR;
							state_n = (cmd_q == CMD_GET) ? S_GET_CAP : S_DEL_CAP;
						end else begin
							st_n    = ST_BAD;
							state_n = S_FINISH;
						end
					end
					CMD_SET: begin
						state_n = S_FINISH;
						if (stat.idx_lt_fill) begin
							op = OP_SET;
						end else begin
							st_n = ST_BAD;
						end
					end
					CMD_SRCH, CMD_SRCH_T, CMD_SRCH_H: begin
						st_n    = ST_MISS;
						state_n = S_SRCH_RD;
					end
					CMD_BINARY: begin
						st_n    = ST_MISS;
						state_n = S_BIN_RD;
					end
					CMD_MAX, CMD_MIN, CMD_SUM, CMD_AVG: state_n = S_RED_RD;
					default: begin
						st_n    = ST_BAD;
						state_n = S_FINISH;
					end
				endcase
			end
			S_INS_RD: begin
				if (stat.ptr_gt_idx) begin
					op      = OP_RD_PREV;
					state_n = S_INS_WR;
				end else begin
					op      = OP_INS_END;
					state_n = S_FINISH;
				end
			end
			S_INS_WR: begin
				op      = OP_WR_DEC;
				state_n = S_INS_RD;
			end
			S_DEL_CAP: begin
				op      = OP_DEL_CAP;
				state_n = S_DEL_RD;
			end
			S_DEL_RD: begin
				if (stat.ptr_next_lt_fill) begin
					op      = OP_RD_NEXT;
					state_n = S_DEL_WR;
				end else begin
					op      = OP_DEL_END;
					state_n = S_FINISH;
				end
			end
			S_DEL_WR: begin
				op      = OP_WR_INC;
				state_n = S_DEL_RD;
			end
			S_SRCH_RD: begin
				if (stat.ptr_lt_fill) begin
					op      = OP_RD_PTR;
					state_n = S_SRCH_CMP;
				end else begin
					state_n = S_FINISH;
				end
			end
			S_SRCH_CMP: begin
				if (stat.match) begin
					st_n = ST_OK;
					if (cmd_q == CMD_SRCH || (cmd_q == CMD_SRCH_T && stat.ptr_zero)) begin
						op      = OP_FOUND;
						state_n = S_FINISH;
					end else begin
						op      = OP_SWAP_RD;
						state_n = S_SWAP_WR;
					end
				end else begin
					op      = OP_NEXT;
					state_n = S_SRCH_RD;
				end
			end
			S_SWAP_WR: begin
				op      = OP_SWAP_WR;
				state_n = S_SWAP_KEY;
			end
			S_SWAP_KEY: begin
				op      = OP_SWAP_KEY;
				state_n = S_FINISH;
			end
			S_BIN_RD: begin
				if (stat.bin_open) begin
					op      = OP_RD_MID;
					state_n = S_BIN_CMP;
				end else begin
					state_n = S_FINISH;
				end
			end
			S_BIN_CMP: begin
				if (stat.match) begin
					st_n    = ST_OK;
					op      = OP_BIN_HIT;
					state_n = S_FINISH;
				end else begin
					op      = OP_BIN_STEP;
					state_n = S_BIN_RD;
				end
			end
			S_GET_CAP: begin
				op      = OP_GET;
				state_n = S_FINISH;
			end
			S_RED_RD: begin
				if (stat.ptr_lt_fill) begin
					op      = OP_RD_PTR;
					state_n = S_RED_ACC;
				end else if (cmd_q == CMD_AVG && !stat.fill_zero) begin
					op      = OP_DIV_INIT;
					state_n = S_DIV;
				end else begin
					if (stat.fill_zero && cmd_q != CMD_SUM) begin
						st_n = ST_EMPTY;
					end
					state_n = S_FINISH;
				end
			end
			S_RED_ACC: begin
				op      = OP_ACC;
				state_n = S_RED_RD;
			end
			S_DIV: begin
				op = OP_DIV_STEP;
				if (stat.div_last) begin
					state_n = S_FINISH;
				end
			end
			S_FINISH: begin
				op      = OP_FINISH;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_APPEND;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_n;
			cmd_q   <= cmd_n;
			st_q    <= st_n;
		end
	end

	assign ctrl = '{op: op, status: st_q};
	assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

// File: rtl/bounded_array_table_engine.sv
// Top level of the bounded array table engine: controller plus datapath.
// Append, set and bad-index commands are the shortest; shifts, walks and reductions
//   take longer the more entries they cover, and the average adds a restoring division.
// Throughput: one command at a time; busy stays high from the accepting edge until
//   the result strobe, bounded by the single-port walk over the entry memory.
// Reset: arst_n clears the fill count, sets capacity to 256 and idles the controller;
//   entry contents are left as they are. Results are never stalled by the receiver.
`default_nettype none

module bounded_array_table_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// command beat
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [3:0]                   command,
	input  wire logic [bate_pkg::IDX_W-1:0]   index,
	input  wire logic signed [bate_pkg::IN_W-1:0] value,
	// result beat, one cycle wide
	output logic                              done,
	output logic [1:0]                        status,
	output logic signed [bate_pkg::RES_W-1:0] result_value,
	output logic [bate_pkg::RI_W-1:0]         result_index,
	// capacity write channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [bate_pkg::CAP_W-1:0]   cfg_data
);
	import bate_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;
	logic     cfg_we;

	// take a capacity beat only between commands
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	bate_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.ctrl    (ctrl),
		.busy    (busy)
	);

	// memory, pointer, accumulators and divider live here
	bate_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.index        (index),
		.value        (value),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.ctrl         (ctrl),
		.stat         (stat),
		.done         (done),
		.status       (status),
		.result_value (result_value),
		.result_index (result_index)
	);

endmodule

`default_nettype wire

// File: test/bounded_array_table_engine_tb.sv
// Self-checking testbench for the bounded array table engine.
`default_nettype none

// Scoreboard: keeps its own copy of the table and capacity and predicts each result.
class table_scoreboard;
	logic signed [31:0] tbl [256];
	int unsigned fill;
	int unsigned cap;
	logic [1:0] want_status [$];
	logic signed [39:0] want_value [$];
	logic [7:0] want_index [$];
	int errors;

	function void clear();
		fill = 0;
		cap = 256;
		errors = 0;
		foreach (tbl[i]) tbl[i] = '0;
	endfunction

	function int unsigned pending();
		return want_status.size();
	endfunction

	function void set_capacity(logic [8:0] c);
		cap = c;
	endfunction

	// Work out the expected result of one accepted command and queue it.
	function void note_command(logic [3:0] cmd, logic [8:0] idx, logic signed [31:0] val);
		logic [1:0] st;
		logic signed [39:0] rv;
		int unsigned ri;
		int unsigned lim;
		int lo, hi, mid;
		logic signed [31:0] t;
		logic signed [39:0] acc;
		st = bate_pkg::ST_OK;
		rv = '0;
		ri = 0;
		lim = (cap < 256) ? cap : 256;
		case (cmd)
		bate_pkg::CMD_APPEND: begin
			if (fill < lim) begin
				tbl[fill] = val;
				ri = fill;
				fill++;
			end else st = bate_pkg::ST_BAD;
		end
		bate_pkg::CMD_INSERT: begin
			if (fill < lim && idx <= fill) begin
				for (int i = fill; i > idx; i--) tbl[i] = tbl[i-1];
				tbl[idx] = val;
				ri = idx;
				fill++;
			end else st = bate_pkg::ST_BAD;
		end
		bate_pkg::CMD_DELETE: begin
			if (idx < fill) begin
				rv = tbl[idx];
				for (int i = idx; i + 1 < fill; i++) tbl[i] = tbl[i+1];
				fill--;
				ri = idx;
			end else st = bate_pkg::ST_BAD;
		end
		bate_pkg::CMD_SRCH, bate_pkg::CMD_SRCH_T, bate_pkg::CMD_SRCH_H: begin
			st = bate_pkg::ST_MISS;
			for (int i = 0; i < fill; i++) begin
				if (tbl[i] == val) begin
					st = bate_pkg::ST_OK;
					ri = i;
					if (cmd == bate_pkg::CMD_SRCH_T && i > 0) begin
						t = tbl[i]; tbl[i] = tbl[i-1]; tbl[i-1] = t;
						ri = i - 1;
					end else if (cmd == bate_pkg::CMD_SRCH_H) begin
						t = tbl[i]; tbl[i] = tbl[0]; tbl[0] = t;
						ri = 0;
					end
					break;
				end
			end
		end
		bate_pkg::CMD_BINARY: begin
			st = bate_pkg::ST_MISS;
			lo = 0;
			hi = int'(fill) - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (tbl[mid] == val) begin
					st = bate_pkg::ST_OK;
					ri = mid;
					break;
				end else if (val < tbl[mid]) hi = mid - 1;
				else lo = mid + 1;
			end
		end
		bate_pkg::CMD_GET: begin
			if (idx < fill) begin
				rv = tbl[idx];
				ri = idx;
			end else begin
				st = bate_pkg::ST_BAD;
				rv = -40'sd1;
			end
		end
		bate_pkg::CMD_SET: begin
			if (idx < fill) begin
				tbl[idx] = val;
				ri = idx;
			end else st = bate_pkg::ST_BAD;
		end
		bate_pkg::CMD_MAX, bate_pkg::CMD_MIN: begin
			rv = (cmd == bate_pkg::CMD_MAX) ? 40'(bate_pkg::VAL_MIN) : 40'(bate_pkg::VAL_MAX);
			if (fill == 0) st = bate_pkg::ST_EMPTY;
			for (int i = 0; i < fill; i++)
				if (cmd == bate_pkg::CMD_MAX ? 40'(tbl[i]) > rv : 40'(tbl[i]) < rv)
					rv = tbl[i];
		end
		bate_pkg::CMD_SUM, bate_pkg::CMD_AVG: begin
			acc = '0;
			for (int i = 0; i < fill; i++) acc += 40'(tbl[i]);
			if (cmd == bate_pkg::CMD_SUM) rv = acc;
			else if (fill == 0) st = bate_pkg::ST_EMPTY;
			else rv = acc / $signed({1'b0, 39'(fill)});
		end
		default: st = bate_pkg::ST_BAD;
		endcase
		want_status.push_back(st);
		want_value.push_back(rv);
		want_index.push_back(8'(ri));
	endfunction

	// Compare one result beat with the oldest expectation.
	function void check_result(logic [1:0] st, logic signed [39:0] rv, logic [7:0] ri);
		if (want_status.size() == 0) begin
			$display("%0t: result with nothing expected: status %0d value %0d index %0d",
				$time, st, rv, ri);
			errors++;
			return;
		end
		if (st !== want_status[0]) begin
			$display("%0t: status expected %0d actual %0d", $time, want_status[0], st);
			errors++;
		end
		if (rv !== want_value[0]) begin
			$display("%0t: result_value expected %0d actual %0d", $time, want_value[0], rv);
			errors++;
		end
		if (ri !== want_index[0]) begin
			$display("%0t: result_index expected %0d actual %0d", $time, want_index[0], ri);
			errors++;
		end
		void'(want_status.pop_front());
		void'(want_value.pop_front());
		void'(want_index.pop_front());
	endfunction
endclass

module bounded_array_table_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [3:0] command;
	logic [8:0] index;
	logic signed [31:0] value;
	logic done;
	logic [1:0] status;
	logic signed [39:0] result_value;
	logic [7:0] result_index;
	logic cfg_valid;
	logic cfg_ready;
	logic [8:0] cfg_data;

	table_scoreboard board;
	int send_idle_pct;
	int quiet_cycles;
	logic signed [31:0] recent_keys [$];

	bounded_array_table_engine dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .command(command), .index(index), .value(value),
		.done(done), .status(status), .result_value(result_value),
		.result_index(result_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every result beat at the edge that ends its strobe cycle; also run the watchdog,
	// which counts edges where neither a command, a result nor a config write is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_result(status, result_value, result_index);
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("bounded_array_table_engine regression: fail");
				$finish;
			end
		end
	end

	// Present one command beat, holding start until the engine takes it; the prediction
	// is made on the accepting edge so it sees the table state in command order.
	// Start stays high after the beat and drops only on an idle cycle or a drain.
	task automatic send_command(logic [3:0] cmd, logic [8:0] idx, logic signed [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		index <= idx;
		value <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_command(cmd, idx, val);
		if (cmd == bate_pkg::CMD_APPEND || cmd == bate_pkg::CMD_INSERT) begin
			recent_keys.push_back(val);
			if (recent_keys.size() > 16) void'(recent_keys.pop_front());
		end
	endtask

	// Drain outstanding results, then let the engine settle before touching capacity.
	task automatic wait_idle();
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_capacity(logic [8:0] c);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_capacity(c);
		cfg_valid <= 1'b0;
	endtask

	// Pick a key: mostly from recently stored values so searches hit, sometimes extremes.
	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 55 && recent_keys.size() > 0)
			return recent_keys[$urandom_range(recent_keys.size() - 1)];
		if (r < 65) return bate_pkg::VAL_MAX;
		if (r < 75) return bate_pkg::VAL_MIN;
		if (r < 85) return 32'($signed($urandom_range(20)) - 10);
		return $urandom;
	endfunction

	// Pick an index: mostly in range of the current fill, some just past it, some wild.
	function automatic logic [8:0] pick_index();
		int r;
		r = $urandom_range(99);
		if (r < 80) return 9'($urandom_range(board.fill));
		if (r < 90) return 9'(board.fill + $urandom_range(2));
		return 9'($urandom);
	endfunction

	task automatic random_phase(int count, int idle_pct);
		logic [3:0] cmd;
		int r;
		send_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			// Bias towards growing the table while it is small, towards shrinking when large.
			if (r < 20) cmd = (board.fill < 40) ? bate_pkg::CMD_APPEND : bate_pkg::CMD_DELETE;
			else if (r < 97) cmd = 4'($urandom_range(12));
			else cmd = 4'($urandom_range(15, 13));
			send_command(cmd, pick_index(), pick_key());
		end
	endtask

	initial begin
		board = new();
		board.clear();
		arst_n = 1'b0;
		start = 1'b0;
		command = bate_pkg::CMD_APPEND;
		index = '0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table cases, extremes, every command, bad indexes, unknown command.
		send_command(bate_pkg::CMD_MAX, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_MIN, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_SUM, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_AVG, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_SRCH, 9'd0, 32'sd5);
		send_command(bate_pkg::CMD_GET, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_APPEND, 9'd0, bate_pkg::VAL_MIN);
		send_command(bate_pkg::CMD_APPEND, 9'd511, bate_pkg::VAL_MAX);
		send_command(bate_pkg::CMD_INSERT, 9'd1, -32'sd1);
		send_command(bate_pkg::CMD_INSERT, 9'd9, 32'sd7);
		send_command(bate_pkg::CMD_APPEND, 9'd0, -32'sd3);
		send_command(bate_pkg::CMD_SRCH_T, 9'd0, -32'sd3);
		send_command(bate_pkg::CMD_SRCH_H, 9'd0, bate_pkg::VAL_MAX);
		send_command(bate_pkg::CMD_BINARY, 9'd0, -32'sd1);
		send_command(bate_pkg::CMD_SET, 9'd2, 32'sh5555_AAAA);
		send_command(bate_pkg::CMD_SET, 9'd511, 32'sd1);
		send_command(bate_pkg::CMD_GET, 9'd2, 32'sd0);
		send_command(bate_pkg::CMD_MAX, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_MIN, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_SUM, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_AVG, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_DELETE, 9'd0, 32'sd0);
		send_command(bate_pkg::CMD_DELETE, 9'd300, 32'sd0);
		send_command(4'd15, 9'd0, 32'sd0);

		// Capacity 0: always full; then a small limit below the fill count.
		write_capacity(9'd0);
		send_command(bate_pkg::CMD_APPEND, 9'd0, 32'sd1);
		write_capacity(9'd2);
		send_command(bate_pkg::CMD_INSERT, 9'd0, 32'sd1);
		write_capacity(9'd511);

		random_phase(160, 0);
		write_capacity(9'd12);
		random_phase(350, 51);
		write_capacity(9'd256);
		random_phase(350, 0);
		write_capacity(9'd1);
		random_phase(150, 36);
		write_capacity(9'd64);
		random_phase(350, 51);
		// Fill deep for long shifts and walks, with sorted content for binary hits.
		while (board.fill > 0) send_command(bate_pkg::CMD_DELETE, 9'd0, 32'sd0);
		write_capacity(9'd256);
		for (int i = 0; i < 256; i++)
			send_command(bate_pkg::CMD_APPEND, 9'd0, 32'(i * 1000 - 120000));
		send_command(bate_pkg::CMD_APPEND, 9'd0, 32'sd0);
		for (int i = 0; i < 20; i++) begin
			send_command(bate_pkg::CMD_BINARY, 9'd0, 32'($urandom_range(255) * 1000 - 120000));
			send_command(4'($urandom_range(12)), 9'($urandom_range(260)), $urandom);
		end

		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("bounded_array_table_engine regression: pass");
		else
			$display("bounded_array_table_engine regression: fail");
		$finish;
	end
endmodule

`default_nettype wire

// File: sim.f
rtl/bate_pkg.sv
rtl/bate_dp.sv
rtl/bate_ctrl.sv
rtl/bounded_array_table_engine.sv
test/bounded_array_table_engine_tb.sv
